// ===== design/rfla_pkg.sv =====
// Shared types and constants for the room free-list allocator.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package rfla_pkg;

  localparam int ROOM_W         = 9;
  localparam int GID_W          = 10;
  localparam int IN_TDATA_W     = 16;
  localparam int OUT_TDATA_W    = 24;
  localparam int DEFAULT_GUESTS = 1024;
  localparam int DEFAULT_ROOMS  = 256;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_DEPART = 1'b1;

  // Classified event, handed from the front part to the back part.
  typedef struct packed {
    logic             depart;
    logic             in_range;
    logic [GID_W-1:0] guest_id;
  } op_t;

endpackage

// ===== design/room_free_list_allocator_core.sv =====
// Room free-list allocator: arrival and departure events in, one result per event out.
// Instantiates rfla_front, rfla_queue and rfla_back; depends on rfla_pkg.
//
// Usage:
//   s_axis carries one event per item: tuser is the command (0 arrive,
//   1 depart), tdata[9:0] the guest identifier. m_axis returns one result
//   per event, in order: tdata[8:0] the room assigned or freed (0 if none),
//   tdata[17:9] the peak room count, tuser the out-of-rooms flag.
//   From input accept, each item passes through the queue, the fetch
//   registers and the result register. The back part takes one item at a
//   time: its fetch state reads the guest table and the stack top into
//   registers, its execute state updates them and loads the result register.
//   A two-entry queue sits between the front and back parts, so input is
//   taken while the back part works or the result register waits.
//   When m_axis_tready is low the result is held, the back part stops, and
//   once the queue fills s_axis_tready drops.
//   Reset (rst, synchronous) empties the queue and the result register and
//   restores the free stack to room 1 alone, occupancy 0 and peak 1; the
//   guest table is not cleared.
`timescale 1ns / 1ps

module room_free_list_allocator_core #(
  parameter int GUESTS = rfla_pkg::DEFAULT_GUESTS,
  parameter int ROOMS  = rfla_pkg::DEFAULT_ROOMS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [rfla_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // guest_id[9:0], zero pad
  input  logic                             s_axis_tuser,   // command
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [rfla_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // room[8:0], peak_rooms[17:9], pad
  output logic                             m_axis_tuser    // out_of_rooms
);

  rfla_pkg::op_t                 push_op;
  rfla_pkg::op_t                 head_op;
  logic                          push;
  logic                          queue_full;
  logic                          head_valid;
  logic                          pop;
  logic [rfla_pkg::ROOM_W-1:0]   out_room;
  logic [rfla_pkg::ROOM_W-1:0]   out_peak;

  rfla_front #(
    .GUESTS(GUESTS)
  ) u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .queue_full   (queue_full),
    .push         (push),
    .op           (push_op)
  );

  rfla_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .full      (queue_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_op   (head_op)
  );

  rfla_back #(
    .GUESTS(GUESTS),
    .ROOMS (ROOMS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head_op   (head_op),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_room  (out_room),
    .out_peak  (out_peak),
    .out_oor   (m_axis_tuser)
  );

  assign m_axis_tdata = {
    (rfla_pkg::OUT_TDATA_W - 2 * rfla_pkg::ROOM_W)'(0), out_peak, out_room
  };

endmodule

// ===== design/rfla_front.sv =====
// Front part: takes input items and classifies them into op_t entries.
// Depends on rfla_pkg.
`timescale 1ns / 1ps

module rfla_front #(
  parameter int GUESTS = rfla_pkg::DEFAULT_GUESTS
) (
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [rfla_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input  logic                            s_axis_tuser,
  input  logic                            queue_full,
  output logic                            push,
  output rfla_pkg::op_t                   op
);

  logic [rfla_pkg::GID_W-1:0] gid;

  assign gid           = s_axis_tdata[rfla_pkg::GID_W-1:0];
  assign s_axis_tready = !queue_full;
  assign push          = s_axis_tvalid && !queue_full;

  always_comb begin
    op.depart   = (s_axis_tuser == rfla_pkg::CMD_DEPART);
    // Guests beyond the table are ignored by the back part.
    op.in_range = (32'(gid) < 32'(GUESTS));
    op.guest_id = gid;
  end

endmodule

// ===== design/rfla_queue.sv =====
// Short queue of classified items between the front and back parts.
// Depends on rfla_pkg.
`timescale 1ns / 1ps

module rfla_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rfla_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output rfla_pkg::op_t head_op
);

  localparam int PTR_W = (rfla_pkg::QUEUE_DEPTH > 1) ? $clog2(rfla_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(rfla_pkg::QUEUE_DEPTH + 1);

  rfla_pkg::op_t    slots [rfla_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(rfla_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(rfla_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(rfla_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/rfla_back.sv =====
// Back part: guest room table, LIFO free stack, counters and the result register.
// Depends on rfla_pkg; fed by rfla_queue.
`timescale 1ns / 1ps

module rfla_back #(
  parameter int GUESTS = rfla_pkg::DEFAULT_GUESTS,
  parameter int ROOMS  = rfla_pkg::DEFAULT_ROOMS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        head_valid,
  input  rfla_pkg::op_t               head_op,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rfla_pkg::ROOM_W-1:0] out_room,
  output logic [rfla_pkg::ROOM_W-1:0] out_peak,
  output logic                        out_oor
);

  localparam int TIDX_W = (GUESTS > 1) ? $clog2(GUESTS) : 1;
  localparam int SIDX_W = (ROOMS > 1) ? $clog2(ROOMS) : 1;
  localparam int CNT_W  = $clog2(ROOMS + 1);
  localparam int RW     = rfla_pkg::ROOM_W;
  localparam logic [CNT_W-1:0] ROOMS_C = CNT_W'(ROOMS);

  localparam logic ST_FETCH = 1'b0;
  localparam logic ST_EXEC  = 1'b1;

  logic          state;
  rfla_pkg::op_t op;

  logic [RW-1:0] guest_tbl [GUESTS];
  logic [RW-1:0] stack_mem [ROOMS];
  logic [RW-1:0] tbl_rd;
  logic [RW-1:0] stk_rd;
  logic          bottom_hit;
  logic          bottom_init;

  logic [CNT_W-1:0] depth;
  logic [CNT_W-1:0] occ;
  logic [CNT_W-1:0] peak;
  logic [CNT_W-1:0] depth_next;
  logic [CNT_W-1:0] occ_next;
  logic [CNT_W-1:0] peak_next;

  logic [SIDX_W-1:0] stk_raddr;
  logic [SIDX_W-1:0] stk_waddr;
  logic              stk_we;
  logic              tbl_we;
  logic [RW-1:0]     tbl_wdata;
  logic [RW-1:0]     pop_room;
  logic [RW-1:0]     res_room;
  logic              res_oor;
  logic              fire;

  assign pop       = (state == ST_FETCH) && head_valid;
  assign fire      = (state == ST_EXEC) && (!out_valid || out_ready);
  assign stk_raddr = SIDX_W'(depth - 1'b1);
  assign stk_waddr = SIDX_W'(depth);
  assign pop_room  = bottom_hit ? RW'(1) : stk_rd;

  always_comb begin
    depth_next = depth;
    occ_next   = occ;
    peak_next  = peak;
    stk_we     = 1'b0;
    tbl_we     = 1'b0;
    tbl_wdata  = '0;
    res_room   = '0;
    res_oor    = 1'b0;
    if (op.in_range) begin
      if (!op.depart) begin
        tbl_we = 1'b1;
        // Open a new room when the stack is empty or occupancy would pass the peak.
        if ((peak <= occ) || (depth == '0)) begin
          if (peak >= ROOMS_C) begin
            res_oor = 1'b1;
          end else begin
            peak_next = peak + 1'b1;
            res_room  = RW'(peak + 1'b1);
            occ_next  = occ + 1'b1;
          end
        end else begin
          depth_next = depth - 1'b1;
          res_room   = pop_room;
          occ_next   = occ + 1'b1;
        end
        tbl_wdata = res_room;
      end else begin
        res_room = tbl_rd;
        if (tbl_rd != '0) begin
          tbl_we = 1'b1;
          if (occ != '0) begin
            occ_next = occ - 1'b1;
          end
          // Drop the push when the stack is full.
          if (depth < ROOMS_C) begin
            stk_we     = 1'b1;
            depth_next = depth + 1'b1;
          end
        end
      end
    end
  end

  // Memory reads, issued while fetching an item.
  always_ff @(posedge clk) begin
    if (pop) begin
      op         <= head_op;
      tbl_rd     <= guest_tbl[TIDX_W'(head_op.guest_id)];
      stk_rd     <= stack_mem[stk_raddr];
      bottom_hit <= bottom_init && (stk_raddr == '0);
    end
  end

  // Memory writes, done when the result is committed.
  always_ff @(posedge clk) begin
    if (fire && tbl_we) begin
      guest_tbl[TIDX_W'(op.guest_id)] <= tbl_wdata;
    end
    if (fire && stk_we) begin
      stack_mem[stk_waddr] <= tbl_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_room <= res_room;
      out_peak <= RW'(peak_next);
      out_oor  <= res_oor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_FETCH;
      out_valid   <= 1'b0;
      depth       <= CNT_W'(1);
      occ         <= '0;
      peak        <= CNT_W'(1);
      bottom_init <= 1'b1;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_FETCH: begin
          if (head_valid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (fire) begin
            depth     <= depth_next;
            occ       <= occ_next;
            peak      <= peak_next;
            if (stk_we && (stk_waddr == '0)) begin
              bottom_init <= 1'b0;
            end
            state <= ST_FETCH;
          end
        end
        default: begin
          state <= ST_FETCH;
        end
      endcase
    end
  end

  a_occ_le_peak: assert property (@(posedge clk) disable iff (rst) occ <= peak)
    else $error("occupancy above peak");
  a_depth_le_rooms: assert property (@(posedge clk) disable iff (rst) depth <= ROOMS_C)
    else $error("free stack deeper than the room count");
  a_peak_le_rooms: assert property (@(posedge clk) disable iff (rst)
    (peak <= ROOMS_C) && (peak != '0))
    else $error("peak out of range");
  a_oor_no_room: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_oor) |-> (out_room == '0))
    else $error("room reported with out-of-rooms flag");
  a_exec_after_fetch: assert property (@(posedge clk) disable iff (rst)
    $rose(state) |-> $past(head_valid))
    else $error("execution started without a queued item");

endmodule
